FILE: hw/rtl/opr_pkg.sv
// ============================================================================
// Optimal page replacement package
// Shared sizes, operation codes and the structs that the engine's modules
// pass between one another.
// ============================================================================
package opr_pkg;

  // Sizes
  localparam int MAX_REFS   = 1024;
  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_REFS);
  localparam int CNT_W      = $clog2(MAX_REFS + 1);
  localparam int SLOT_W     = 3;
  localparam int CFG_W      = 4;
  localparam int NF_W       = $clog2(MAX_FRAMES + 1);
  localparam int FAULT_W    = 11;
  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
  localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(4);

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // One input item
  typedef struct packed {
    logic                 operation;
    logic [PAGE_BITS-1:0] page;
    logic                 first;
  } in_t;

  // One result item
  typedef struct packed {
    logic [PAGE_BITS-1:0] ref_page;
    logic                 fault;
    logic [SLOT_W-1:0]    victim_slot;
    logic [FAULT_W-1:0]   fault_total;
    logic                 final_ref;
  } out_t;

  // Reference word travelling down the row of frame cells
  typedef struct packed {
    logic                 vld;
    logic [PAGE_BITS-1:0] data;
    logic [IDX_W-1:0]     idx;
  } stream_t;

  // Controls broadcast to every frame cell
  typedef struct packed {
    logic                 clear_valid;
    logic                 scan_clear;
    logic [PAGE_BITS-1:0] probe;
    logic [PAGE_BITS-1:0] load_page;
  } cell_ctrl_t;

  // Status reported by each frame cell
  typedef struct packed {
    logic             valid;
    logic             match;
    logic             found;
    logic [IDX_W-1:0] next_idx;
  } cell_stat_t;

endpackage

FILE: hw/rtl/opr_ref_store.sv
// ============================================================================
// Reference string store
// Single write port and single read port memory with a registered read.
// ============================================================================
module opr_ref_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic [opr_pkg::IDX_W-1:0]     waddr,
  input  logic [opr_pkg::PAGE_BITS-1:0] wdata,
  input  logic [opr_pkg::IDX_W-1:0]     raddr,
  output logic [opr_pkg::PAGE_BITS-1:0] rdata
);

  logic [opr_pkg::PAGE_BITS-1:0] mem [opr_pkg::MAX_REFS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/opr_cell.sv
// ============================================================================
// Frame cell
// Holds one physical frame and finds that frame's next use as the future
// references stream past it, then hands each reference to its neighbor.
// ============================================================================
module opr_cell (
  input  logic                clk,
  input  logic                rst,
  input  opr_pkg::cell_ctrl_t ctrl,
  input  logic                load,
  input  opr_pkg::stream_t    stream_in,
  output opr_pkg::stream_t    stream_out,
  output opr_pkg::cell_stat_t status
);

  logic                          valid;
  logic                          found;
  logic [opr_pkg::PAGE_BITS-1:0] page;
  logic [opr_pkg::IDX_W-1:0]     next_idx;
  logic                          hit_stream;

  // The first matching reference in stream order is the nearest future use.
  assign hit_stream = stream_in.vld && !found && (stream_in.data == page);

  // Control state and the reference handed to the neighbor.
  always_ff @(posedge clk) begin
    stream_out.data <= stream_in.data;
    stream_out.idx  <= stream_in.idx;
    if (rst) begin
      valid          <= 1'b0;
      found          <= 1'b0;
      stream_out.vld <= 1'b0;
    end else begin
      if (ctrl.clear_valid) begin
        valid <= 1'b0;
      end else if (load) begin
        valid <= 1'b1;
      end
      if (ctrl.scan_clear) begin
        found <= 1'b0;
      end else if (hit_stream) begin
        found <= 1'b1;
      end
      stream_out.vld <= stream_in.vld;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      page <= ctrl.load_page;
    end
    if (hit_stream) begin
      next_idx <= stream_in.idx;
    end
  end

  // Status toward the controller.
  always_comb begin
    status.valid    = valid;
    status.match    = valid && (page == ctrl.probe);
    status.found    = found;
    status.next_idx = next_idx;
  end

endmodule

FILE: hw/rtl/optimal_page_replacement.sv
// ============================================================================
// Optimal page replacement engine
// Stores a reference string and steps through it, replacing frames by the
// farthest-next-use rule with a row of frame cells.
// ============================================================================
//
// Channel   | Signals                  | Transfer
// ----------+--------------------------+-----------------------------------
// input     | start, busy, item        | start high while busy is low
// result    | done, result             | done high, one cycle, no stall
// config    | frames_we, frames_data   | frames_we high
//
// A load completes in the cycle it is accepted and busy stays low.
// A step that hits holds busy only for the probe state; its result shows in the next cycle.
// A step that misses holds busy through the probe, a scan that issues one read
// per remaining reference, a drain down the row of cells until no reference
// is left in flight, and the decision.
// Reset is synchronous and needs no clearing pass; results cannot be stalled.
//
module optimal_page_replacement (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  opr_pkg::in_t             item,
  input  logic                     frames_we,
  input  logic [opr_pkg::CFG_W-1:0] frames_data,
  output logic                     done,
  output opr_pkg::out_t            result
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PROBE  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;

  logic [2:0]                     state;
  logic [opr_pkg::CFG_W-1:0]      frames_cfg;
  logic [opr_pkg::CNT_W-1:0]      count;
  logic [opr_pkg::CNT_W-1:0]      pos;
  logic [opr_pkg::CNT_W-1:0]      scan_j;
  logic [opr_pkg::FAULT_W-1:0]    fault_count;
  logic [opr_pkg::PAGE_BITS-1:0]  probe_page;
  logic                           rd_vld;
  logic [opr_pkg::IDX_W-1:0]      rd_idx;

  logic                           accept;
  logic                           load_op;
  logic                           mem_we;
  logic [opr_pkg::IDX_W-1:0]      mem_waddr;
  logic [opr_pkg::IDX_W-1:0]      mem_raddr;
  logic [opr_pkg::PAGE_BITS-1:0]  mem_rdata;
  logic                           scan_more;

  logic [opr_pkg::NF_W-1:0]       nf;
  logic [opr_pkg::MAX_FRAMES-1:0] active;
  logic                           hit;
  logic [opr_pkg::SLOT_W-1:0]     victim;
  logic [opr_pkg::MAX_FRAMES-1:0] cell_load;
  logic                           in_flight;
  logic [opr_pkg::FAULT_W-1:0]    fault_inc;

  opr_pkg::cell_ctrl_t            ctrl;
  opr_pkg::stream_t               chain [opr_pkg::MAX_FRAMES+1];
  opr_pkg::cell_stat_t            stat  [opr_pkg::MAX_FRAMES];

  // Handshake and load decode.
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign load_op   = accept && (item.operation == opr_pkg::OP_LOAD);
  assign mem_we    = load_op && (item.first || (count < opr_pkg::CNT_W'(opr_pkg::MAX_REFS)));
  assign mem_waddr = item.first ? '0 : count[opr_pkg::IDX_W-1:0];
  assign scan_more = (scan_j < count);
  assign mem_raddr = (state == ST_SCAN) ? scan_j[opr_pkg::IDX_W-1:0]
                                        : pos[opr_pkg::IDX_W-1:0];
  assign fault_inc = (fault_count == opr_pkg::FAULT_MAX) ? fault_count
                                                         : fault_count + 1'b1;

  opr_ref_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (item.page),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Active frame count, clamped to the legal range.
  always_comb begin
    if (frames_cfg == '0) begin
      nf = opr_pkg::NF_W'(1);
    end else if (int'(frames_cfg) > opr_pkg::MAX_FRAMES) begin
      nf = opr_pkg::NF_W'(opr_pkg::MAX_FRAMES);
    end else begin
      nf = opr_pkg::NF_W'(frames_cfg);
    end
    for (int f = 0; f < opr_pkg::MAX_FRAMES; f++) begin
      active[f] = (f < int'(nf));
    end
  end

  // Broadcast controls to the cells.
  always_comb begin
    ctrl.clear_valid = load_op && item.first;
    ctrl.scan_clear  = (state == ST_PROBE);
    ctrl.probe       = mem_rdata;
    ctrl.load_page   = probe_page;
  end

  // Hit detection over the active frames.
  always_comb begin
    hit = 1'b0;
    for (int f = 0; f < opr_pkg::MAX_FRAMES; f++) begin
      if (active[f] && stat[f].match) begin
        hit = 1'b1;
      end
    end
  end

  // Victim choice: first empty or unused frame, else farthest next use.
  always_comb begin
    logic                      chosen;
    logic [opr_pkg::CNT_W-1:0] far;
    chosen = 1'b0;
    victim = '0;
    far    = pos + 1'b1;
    for (int f = 0; f < opr_pkg::MAX_FRAMES; f++) begin
      if (active[f] && !chosen) begin
        if (!stat[f].valid || !stat[f].found) begin
          victim = opr_pkg::SLOT_W'(f);
          chosen = 1'b1;
        end else if (opr_pkg::CNT_W'(stat[f].next_idx) > far) begin
          far    = opr_pkg::CNT_W'(stat[f].next_idx);
          victim = opr_pkg::SLOT_W'(f);
        end
      end
    end
    for (int f = 0; f < opr_pkg::MAX_FRAMES; f++) begin
      cell_load[f] = (state == ST_DECIDE) && (victim == opr_pkg::SLOT_W'(f));
    end
  end

  // Any reference still moving down the row.
  always_comb begin
    in_flight = 1'b0;
    for (int k = 0; k <= opr_pkg::MAX_FRAMES; k++) begin
      in_flight = in_flight | chain[k].vld;
    end
  end

  // Row of frame cells.
  always_comb begin
    chain[0].vld  = rd_vld;
    chain[0].data = mem_rdata;
    chain[0].idx  = rd_idx;
  end

  for (genvar g = 0; g < opr_pkg::MAX_FRAMES; g++) begin : g_cell
    opr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .load       (cell_load[g]),
      .stream_in  (chain[g]),
      .stream_out (chain[g+1]),
      .status     (stat[g])
    );
  end

  // Sequencer and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      frames_cfg  <= opr_pkg::FRAMES_RESET;
      count       <= '0;
      pos         <= '0;
      fault_count <= '0;
      rd_vld      <= 1'b0;
      done        <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= 1'b0;
      if (frames_we) begin
        frames_cfg <= frames_data;
      end
      case (state)
        ST_IDLE: begin
          if (load_op) begin
            if (item.first) begin
              count       <= opr_pkg::CNT_W'(1);
              pos         <= '0;
              fault_count <= '0;
            end else if (mem_we) begin
              count <= count + 1'b1;
            end
          end else if (accept && (pos < count)) begin
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (hit) begin
            done  <= 1'b1;
            pos   <= pos + 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_more) begin
            rd_vld <= 1'b1;
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!in_flight) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          done        <= 1'b1;
          fault_count <= fault_inc;
          pos         <= pos + 1'b1;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers and the result word.
  always_ff @(posedge clk) begin
    rd_idx <= scan_j[opr_pkg::IDX_W-1:0];
    if (state == ST_PROBE) begin
      probe_page <= mem_rdata;
      scan_j     <= pos + 1'b1;
    end else if (state == ST_SCAN && scan_more) begin
      scan_j <= scan_j + 1'b1;
    end
    if (state == ST_PROBE) begin
      result.ref_page    <= mem_rdata;
      result.fault       <= 1'b0;
      result.victim_slot <= '0;
      result.fault_total <= fault_count;
      result.final_ref   <= ((pos + 1'b1) == count);
    end else if (state == ST_DECIDE) begin
      result.ref_page    <= probe_page;
      result.fault       <= 1'b1;
      result.victim_slot <= victim;
      result.fault_total <= fault_inc;
      result.final_ref   <= ((pos + 1'b1) == count);
    end
  end

  // Results leave only from the probe or decide steps.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_PROBE || $past(state) == ST_DECIDE))
    else $error("result transfer without a probe or decide step");

  // A fault loads exactly one frame, and nothing else loads a frame.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) |-> $onehot(cell_load))
    else $error("decide step did not load exactly one frame");

  assert property (@(posedge clk) disable iff (rst)
    (state != ST_DECIDE) |-> (cell_load == '0))
    else $error("frame loaded outside the decide step");

  // The step position never runs past the stored string.
  assert property (@(posedge clk) disable iff (rst) pos <= count)
    else $error("step position beyond reference count");

  // The fault count only drops when a new string starts.
  assert property (@(posedge clk) disable iff (rst)
    !(load_op && item.first) |=> (fault_count >= $past(fault_count)))
    else $error("fault count decreased");

endmodule
